[sv/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCKS     = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = BLOCKS / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = 13;
    localparam int IDX_W      = 12;
    localparam int RANGE_W    = CNT_W + 1;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;
    localparam int CHUNK_W    = $clog2(CHUNKS);
    localparam int CHUNK_SH   = $clog2(CHUNK_BITS);
    localparam int POP_W      = BIT_W + 1;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } bba_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INIT_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_BITS,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_QRY_RD,
        ST_QRY_CHK,
        ST_FINISH
    } bba_state_t;

    typedef struct packed {
        logic load;
        logic init_wr;
        logic rd;
        logic scan_chk;
        logic scan_bits;
        logic rmw_wr;
        logic qry_chk;
        logic finish;
    } bba_cmd_t;

    typedef struct packed {
        bba_op_t op;
        logic    cnt_zero;
        logic    free_empty;
        logic    last_word;
        logic    fast_skip;
        logic    hit;
        logic    chunk_last;
        logic    rmw_last;
        logic    out_busy;
    } bba_stat_t;

    // Bits of map word word_idx whose block number is at or above x.
    function automatic word_t ones_from(input logic [WORD_AW-1:0] word_idx,
                                        input logic [RANGE_W-1:0] x);
        logic [RANGE_W-1:0] base;
        logic [RANGE_W-1:0] off;
        word_t              res;
        base = RANGE_W'({word_idx, BIT_W'(0)});
        off  = x - base;
        if (x <= base)
        begin
            res = {WORD_BITS{1'b1}};
        end
        else if (x >= base + RANGE_W'(WORD_BITS))
        begin
            res = '0;
        end
        else
        begin
            res = {WORD_BITS{1'b1}} << off[BIT_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a 4096-block usage bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation, block_index and
//   count; output channel (out_valid/out_ready) returns success,
//   start_block, block_used and free_blocks, one result per transaction.
//   cfg_wr_en/cfg_index/cfg_data write total_blocks (0) and
//   reserved_blocks (1); the user must write them only while the block is
//   idle, which the block itself does not enforce.
//   One transaction is processed at a time; the bitmap is 128 words of 32
//   bits in a single-port memory with registered read:
//     init   : one word written per cycle
//     alloc  : skips fully used words and free words short of the run, scans
//              others 8 bits per cycle, then rewrites each word of the run
//     free   : each word touched is read and written back
//     query  : the block's word is read and its bit checked
//   Reset: every block reads as used, used count 4096, total 4096,
//   reserved 0; no clearing pass is needed.
//   The result sits in an output register; the next transaction is taken
//   while it waits, and processing holds at completion until it is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [bba_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [bba_pkg::IDX_W-1:0]   block_index,
    input  logic [bba_pkg::CNT_W-1:0]   count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        success,
    output logic [bba_pkg::IDX_W-1:0]   start_block,
    output logic                        block_used,
    output logic [bba_pkg::CNT_W-1:0]   free_blocks
);

    bba_pkg::bba_cmd_t  cmd;
    bba_pkg::bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .block_index (block_index),
        .count       (count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .success     (success),
        .start_block (start_block),
        .block_used  (block_used),
        .free_blocks (free_blocks)
    );

endmodule

[sv/bba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: decodes each transaction and steps the
// datapath through init, first-fit scan, run update and query.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);

    bba_pkg::bba_state_t state_reg;
    bba_pkg::bba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bba_pkg::ST_DECODE;
                end
            end
            bba_pkg::ST_DECODE:
            begin
                unique case (stat.op)
                    bba_pkg::OP_INIT:  state_next = bba_pkg::ST_INIT_WR;
                    bba_pkg::OP_ALLOC: state_next = stat.cnt_zero ? bba_pkg::ST_FINISH
                                                                  : bba_pkg::ST_SCAN_RD;
                    bba_pkg::OP_FREE:  state_next = stat.free_empty ? bba_pkg::ST_FINISH
                                                                    : bba_pkg::ST_RMW_RD;
                    bba_pkg::OP_QUERY: state_next = bba_pkg::ST_QRY_RD;
                    default:           state_next = bba_pkg::ST_FINISH;
                endcase
            end
            bba_pkg::ST_INIT_WR:
            begin
                if (stat.last_word)
                begin
                    state_next = bba_pkg::ST_FINISH;
                end
            end
            bba_pkg::ST_SCAN_RD:
            begin
                state_next = bba_pkg::ST_SCAN_CHK;
            end
            bba_pkg::ST_SCAN_CHK:
            begin
                if (!stat.fast_skip)
                begin
                    state_next = bba_pkg::ST_SCAN_BITS;
                end
                else if (stat.last_word)
                begin
                    state_next = bba_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_SCAN_BITS:
            begin
                if (stat.hit)
                begin
                    state_next = bba_pkg::ST_RMW_RD;
                end
                else if (stat.chunk_last)
                begin
                    state_next = stat.last_word ? bba_pkg::ST_FINISH : bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_RMW_RD:
            begin
                state_next = bba_pkg::ST_RMW_WR;
            end
            bba_pkg::ST_RMW_WR:
            begin
                if (stat.rmw_last)
                begin
                    state_next = bba_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = bba_pkg::ST_RMW_RD;
                end
            end
            bba_pkg::ST_QRY_RD:
            begin
                state_next = bba_pkg::ST_QRY_CHK;
            end
            bba_pkg::ST_QRY_CHK:
            begin
                state_next = bba_pkg::ST_FINISH;
            end
            bba_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bba_pkg::ST_INIT_WR:   cmd.init_wr   = 1'b1;
            bba_pkg::ST_SCAN_RD:   cmd.rd        = 1'b1;
            bba_pkg::ST_SCAN_CHK:  cmd.scan_chk  = 1'b1;
            bba_pkg::ST_SCAN_BITS: cmd.scan_bits = 1'b1;
            bba_pkg::ST_RMW_RD:    cmd.rd        = 1'b1;
            bba_pkg::ST_RMW_WR:    cmd.rmw_wr    = 1'b1;
            bba_pkg::ST_QRY_RD:    cmd.rd        = 1'b1;
            bba_pkg::ST_QRY_CHK:   cmd.qry_chk   = 1'b1;
            bba_pkg::ST_FINISH:    cmd.finish    = !stat.out_busy;
            default:               cmd           = '0;
        endcase
    end

endmodule

[sv/bba_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Usage bitmap memory, configuration registers, used-block counter, run
// scanner and result register of the allocator.
// ----------------------------------------------------------------------------
module bba_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bba_pkg::bba_cmd_t           cmd,
    output bba_pkg::bba_stat_t          stat,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [bba_pkg::CNT_W-1:0]   cfg_data,
    input  logic [1:0]                  operation,
    input  logic [bba_pkg::IDX_W-1:0]   block_index,
    input  logic [bba_pkg::CNT_W-1:0]   count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        success,
    output logic [bba_pkg::IDX_W-1:0]   start_block,
    output logic                        block_used,
    output logic [bba_pkg::CNT_W-1:0]   free_blocks
);

    localparam int CNT_W   = bba_pkg::CNT_W;
    localparam int IDX_W   = bba_pkg::IDX_W;
    localparam int RANGE_W = bba_pkg::RANGE_W;
    localparam int WORD_AW = bba_pkg::WORD_AW;
    localparam int BIT_W   = bba_pkg::BIT_W;
    localparam int CHUNK_W = bba_pkg::CHUNK_W;
    localparam int CHUNK_SH = bba_pkg::CHUNK_SH;
    localparam int CHUNK_BITS = bba_pkg::CHUNK_BITS;
    localparam int POP_W   = bba_pkg::POP_W;

    bba_pkg::word_t mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0] valid_reg;

    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   reserved_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    bba_pkg::bba_op_t   op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WORD_AW-1:0] ptr_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [IDX_W-1:0]   first_reg;
    logic               found_reg;
    logic [RANGE_W-1:0] lo_reg;
    logic [RANGE_W-1:0] hi_reg;
    logic               qry_used_reg;
    bba_pkg::word_t     buf_reg;
    bba_pkg::word_t     rd_data_reg;
    logic               rd_valid_reg;

    logic               out_valid_reg;
    logic               success_reg;
    logic [IDX_W-1:0]   start_reg;
    logic               used_out_reg;
    logic [CNT_W-1:0]   free_reg;

    logic [CNT_W-1:0]   eff_total;
    logic [CNT_W-1:0]   eff_res;
    logic [RANGE_W-1:0] total_w;
    bba_pkg::word_t     word_cur;
    bba_pkg::word_t     scan_word;
    bba_pkg::word_t     range_mask;
    bba_pkg::word_t     rmw_word;
    bba_pkg::word_t     init_word;
    bba_pkg::word_t     mem_wdata;
    logic               mem_we;
    logic [RANGE_W-1:0] run_plus;
    logic               word_full;
    logic               word_empty;
    logic               fast_skip;
    logic [RANGE_W-1:0] free_end;
    logic [RANGE_W-1:0] next_base;
    logic [RANGE_W-1:0] alloc_sum;
    logic [POP_W-1:0]   freed;
    logic               last_word;
    logic               chunk_last;
    logic [CHUNK_BITS-1:0] chunk_bits;
    logic [CNT_W-1:0]   run_v;
    logic [IDX_W-1:0]   first_v;
    logic               hit_v;

    assign eff_total = (total_reg > CNT_W'(bba_pkg::BLOCKS)) ? CNT_W'(bba_pkg::BLOCKS)
                                                              : total_reg;
    assign eff_res   = (reserved_reg > eff_total) ? eff_total : reserved_reg;
    assign total_w   = RANGE_W'(eff_total);

    assign word_cur  = rd_valid_reg ? rd_data_reg : '1;
    // blocks past the total count as used so no run crosses the end
    assign scan_word = word_cur | bba_pkg::ones_from(ptr_reg, total_w);
    assign run_plus  = RANGE_W'(run_reg) + RANGE_W'(bba_pkg::WORD_BITS);
    assign word_full  = &scan_word;
    assign word_empty = ~|scan_word;
    assign fast_skip  = word_full || (word_empty && (run_plus < RANGE_W'(cnt_reg)));

    assign range_mask = bba_pkg::ones_from(ptr_reg, lo_reg) &
                        ~bba_pkg::ones_from(ptr_reg, hi_reg);
    assign rmw_word   = (op_reg == bba_pkg::OP_ALLOC) ? (word_cur | range_mask)
                                                      : (word_cur & ~range_mask);
    assign freed      = POP_W'($countones(word_cur & range_mask));
    assign init_word  = ~(bba_pkg::ones_from(ptr_reg, RANGE_W'(eff_res)) &
                          ~bba_pkg::ones_from(ptr_reg, total_w));
    assign mem_we     = cmd.init_wr || cmd.rmw_wr;
    assign mem_wdata  = cmd.init_wr ? init_word : rmw_word;

    assign free_end   = RANGE_W'(block_index) + RANGE_W'(count);
    assign next_base  = RANGE_W'({ptr_reg, BIT_W'(0)}) + RANGE_W'(bba_pkg::WORD_BITS);
    assign alloc_sum  = RANGE_W'(used_reg) + RANGE_W'(cnt_reg);
    assign last_word  = (ptr_reg == WORD_AW'(bba_pkg::MAP_WORDS - 1));
    assign chunk_last = (chunk_reg == CHUNK_W'(bba_pkg::CHUNKS - 1));
    assign chunk_bits = CHUNK_BITS'(buf_reg >> {chunk_reg, CHUNK_SH'(0)});

    // first-fit over one chunk of the buffered word
    always_comb
    begin
        run_v   = run_reg;
        first_v = first_reg;
        hit_v   = 1'b0;
        for (int j = 0; j < CHUNK_BITS; j++)
        begin
            if (!hit_v)
            begin
                if (!chunk_bits[j])
                begin
                    if (run_v == '0)
                    begin
                        first_v = IDX_W'({ptr_reg, chunk_reg, CHUNK_SH'(j)});
                    end
                    run_v = run_v + CNT_W'(1);
                    if (run_v == cnt_reg)
                    begin
                        hit_v = 1'b1;
                    end
                end
                else
                begin
                    run_v = '0;
                end
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        priority if (cmd.init_wr && last_word)
        begin
            used_next = eff_res;
        end
        else if (cmd.rmw_wr && (op_reg == bba_pkg::OP_ALLOC) && (next_base >= hi_reg))
        begin
            used_next = (alloc_sum > RANGE_W'(bba_pkg::BLOCKS)) ? CNT_W'(bba_pkg::BLOCKS)
                                                                : CNT_W'(alloc_sum);
        end
        else if (cmd.rmw_wr && (op_reg == bba_pkg::OP_FREE))
        begin
            used_next = (used_reg >= CNT_W'(freed)) ? (used_reg - CNT_W'(freed)) : '0;
        end
        else
        begin
            used_next = used_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.free_empty = (idx_reg == '0) || (hi_reg <= lo_reg);
    assign stat.last_word  = last_word;
    assign stat.fast_skip  = fast_skip;
    assign stat.hit        = hit_v;
    assign stat.chunk_last = chunk_last;
    assign stat.rmw_last   = (next_base >= hi_reg);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // bitmap storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            total_reg     <= CNT_W'(bba_pkg::BLOCKS);
            reserved_reg  <= '0;
            used_reg      <= CNT_W'(bba_pkg::BLOCKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[ptr_reg];
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == bba_pkg::CFG_TOTAL)
                begin
                    total_reg <= cfg_data;
                end
                else
                begin
                    reserved_reg <= cfg_data;
                end
            end
            used_reg <= used_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= bba_pkg::bba_op_t'(operation);
            idx_reg   <= block_index;
            cnt_reg   <= count;
            run_reg   <= '0;
            first_reg <= '0;
            found_reg <= 1'b0;
            chunk_reg <= '0;
            lo_reg    <= RANGE_W'(block_index);
            hi_reg    <= (free_end < total_w) ? free_end : total_w;
            if ((operation == bba_pkg::OP_INIT) || (operation == bba_pkg::OP_ALLOC))
            begin
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= block_index[IDX_W-1:BIT_W];
            end
        end
        if (cmd.init_wr || cmd.rmw_wr)
        begin
            ptr_reg <= ptr_reg + WORD_AW'(1);
        end
        if (cmd.scan_chk)
        begin
            if (fast_skip)
            begin
                run_reg <= word_full ? '0 : CNT_W'(run_plus);
                if (!word_full && (run_reg == '0))
                begin
                    first_reg <= IDX_W'({ptr_reg, BIT_W'(0)});
                end
                ptr_reg <= ptr_reg + WORD_AW'(1);
            end
            else
            begin
                buf_reg   <= scan_word;
                chunk_reg <= '0;
            end
        end
        if (cmd.scan_bits)
        begin
            run_reg   <= run_v;
            first_reg <= first_v;
            chunk_reg <= chunk_reg + CHUNK_W'(1);
            if (hit_v)
            begin
                found_reg <= 1'b1;
                lo_reg    <= RANGE_W'(first_v);
                hi_reg    <= RANGE_W'(first_v) + RANGE_W'(cnt_reg);
                ptr_reg   <= first_v[IDX_W-1:BIT_W];
            end
            else if (chunk_last)
            begin
                ptr_reg <= ptr_reg + WORD_AW'(1);
            end
        end
        if (cmd.qry_chk)
        begin
            qry_used_reg <= (CNT_W'(idx_reg) >= eff_total) || word_cur[idx_reg[BIT_W-1:0]];
        end
        if (cmd.finish)
        begin
            success_reg  <= (op_reg != bba_pkg::OP_ALLOC) || found_reg;
            start_reg    <= ((op_reg == bba_pkg::OP_ALLOC) && found_reg) ? first_reg : '0;
            used_out_reg <= (op_reg == bba_pkg::OP_QUERY) && qry_used_reg;
            free_reg     <= (eff_total > used_reg) ? (eff_total - used_reg) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign start_block = start_reg;
    assign block_used  = used_out_reg;
    assign free_blocks = free_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while held");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(bba_pkg::BLOCKS))
        else $error("used block count above capacity");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_bits && hit_v) |-> ((RANGE_W'(first_v) + RANGE_W'(cnt_reg)) <= total_w))
        else $error("allocated run extends past total");

    a_init_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.init_wr && last_word) |=> (&valid_reg))
        else $error("init pass left map words unwritten");

endmodule

[tb/sv/bba_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_tb_pkg
// Scoreboard for the bitmap block allocator: mirrors the usage map, used
// count and registers, predicts one result per accepted request and checks
// returned results in order.
// ----------------------------------------------------------------------------
package bba_tb_pkg;

    import bba_pkg::*;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] start_block;
        logic             block_used;
        logic [CNT_W-1:0] free_blocks;
    } alloc_result_t;

    class block_map_scoreboard;
        bit            used_bit [BLOCKS];
        int unsigned   used_cnt;
        int unsigned   total_reg;
        int unsigned   reserved_reg;
        alloc_result_t pending [$];
        int unsigned   op_seen [4];
        int unsigned   alloc_refused;
        int unsigned   checked;
        int unsigned   errors;

        function new();
            foreach (used_bit[i])
                used_bit[i] = 1'b1;
            used_cnt     = BLOCKS;
            total_reg    = BLOCKS;
            reserved_reg = 0;
        endfunction

        function void write_reg(logic idx, int unsigned val);
            if (idx == CFG_TOTAL)
                total_reg = val & 32'h1FFF;
            else
                reserved_reg = val & 32'h1FFF;
        endfunction

        function int unsigned limit_blocks();
            return (total_reg > BLOCKS) ? BLOCKS : total_reg;
        endfunction

        function alloc_result_t note_request(bba_op_t op, logic [IDX_W-1:0] idx,
                                             logic [CNT_W-1:0] cnt);
            alloc_result_t exp;
            int unsigned   lim;
            int unsigned   resv;
            int unsigned   run;
            int unsigned   first;
            int unsigned   b;
            bit            found;
            lim   = limit_blocks();
            exp   = '0;
            exp.success = 1'b1;
            run   = 0;
            first = 0;
            found = 1'b0;
            op_seen[op]++;
            case (op)
                OP_INIT:
                begin
                    resv = (reserved_reg > lim) ? lim : reserved_reg;
                    for (int i = 0; i < BLOCKS; i++)
                        used_bit[i] = (i < resv) || (i >= lim);
                    used_cnt = resv;
                end
                OP_ALLOC:
                begin
                    if (cnt != 0)
                    begin
                        for (int unsigned i = 0; i < lim && !found; i++)
                        begin
                            if (!used_bit[i])
                            begin
                                if (run == 0)
                                    first = i;
                                run++;
                                found = (run == cnt);
                            end
                            else
                                run = 0;
                        end
                    end
                    if (found)
                    begin
                        for (int unsigned i = first; i < first + cnt; i++)
                            used_bit[i] = 1'b1;
                        used_cnt = used_cnt + cnt;
                        if (used_cnt > BLOCKS)
                            used_cnt = BLOCKS;
                        exp.start_block = first[IDX_W-1:0];
                    end
                    else
                    begin
                        exp.success = 1'b0;
                        alloc_refused++;
                    end
                end
                OP_FREE:
                begin
                    if (idx != 0)
                    begin
                        for (int unsigned i = 0; i < cnt; i++)
                        begin
                            b = idx + i;
                            if (b < lim && used_bit[b])
                            begin
                                used_bit[b] = 1'b0;
                                if (used_cnt > 0)
                                    used_cnt--;
                            end
                        end
                    end
                end
                default:
                    exp.block_used = (idx >= lim) || used_bit[idx];
            endcase
            exp.free_blocks = (lim > used_cnt) ? CNT_W'(lim - used_cnt) : '0;
            pending.push_back(exp);
            return exp;
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (pending.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result transaction: success=%0d start=%0d used=%0d free=%0d",
                             got.success, got.start_block, got.block_used, got.free_blocks);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.success !== exp.success || got.start_block !== exp.start_block ||
                got.block_used !== exp.block_used || got.free_blocks !== exp.free_blocks)
            begin
                if (errors < 10)
                    $display("result %0d wrong: exp success=%0d start=%0d used=%0d free=%0d, got success=%0d start=%0d used=%0d free=%0d",
                             checked, exp.success, exp.start_block, exp.block_used,
                             exp.free_blocks, got.success, got.start_block, got.block_used,
                             got.free_blocks);
                errors++;
            end
        endfunction
    endclass

endpackage

[tb/sv/bitmap_block_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test
// Self-checking bench for the bitmap block allocator. A directed opening
// covers the reset map, refused and ignored requests and first-fit holes;
// random phases then run allocate/free sequences over several register
// settings and handshake pacing modes, with a long output hold-off.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;

    import bba_pkg::*;
    import bba_tb_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASES          = 9;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } block_run_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic             cfg_index   = 1'b0;
    logic [CNT_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [1:0]       operation   = 2'b00;
    logic [IDX_W-1:0] block_index = '0;
    logic [CNT_W-1:0] count       = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic             success;
    logic [IDX_W-1:0] start_block;
    logic             block_used;
    logic [CNT_W-1:0] free_blocks;

    int unsigned phase_total    [PHASES] = '{8191, 300, 4096, 0, 4096, 777, 4096, 64, 1000};
    int unsigned phase_reserved [PHASES] = '{37, 17, 0, 8191, 4096, 3, 5, 0, 999};
    int unsigned phase_items    [PHASES] = '{220, 220, 220, 60, 60, 220, 220, 220, 220};
    bit          phase_init     [PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};

    block_map_scoreboard sb = new();
    block_run_t          live_runs [$];
    int                  sender_idle_pct = 0;
    int                  stall_pct       = 0;
    int                  hold_requests   = 0;
    int                  holds_served    = 0;
    int                  hold_left       = 0;
    int                  idle_cycles     = 0;

    bitmap_block_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .block_index (block_index),
        .count       (count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .success     (success),
        .start_block (start_block),
        .block_used  (block_used),
        .free_blocks (free_blocks)
    );

    always #5 clk = ~clk;

    // Output side: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({success, start_block, block_used, free_blocks});
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input bba_op_t op, input int unsigned idx, input int unsigned cnt);
        alloc_result_t exp;
        block_run_t    run;
        in_valid    <= 1'b1;
        operation   <= op;
        block_index <= idx[IDX_W-1:0];
        count       <= cnt[CNT_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp = sb.note_request(op, idx[IDX_W-1:0], cnt[CNT_W-1:0]);
        if (op == OP_INIT)
            live_runs.delete();
        else if (op == OP_ALLOC && exp.success)
        begin
            run.first = exp.start_block;
            run.len   = cnt[CNT_W-1:0];
            live_runs.push_back(run);
        end
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned total, input int unsigned reserved);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TOTAL;
        cfg_data  <= total[CNT_W-1:0];
        @(posedge clk);
        sb.write_reg(CFG_TOTAL, total);
        cfg_index <= CFG_RESERVED;
        cfg_data  <= reserved[CNT_W-1:0];
        @(posedge clk);
        sb.write_reg(CFG_RESERVED, reserved);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly allocate/free of live runs; the rest is stray frees, queries and occasional inits
    task automatic send_random();
        int unsigned lim;
        int unsigned sel;
        int unsigned pick;
        int unsigned idx;
        int unsigned cnt;
        block_run_t  run;
        lim = sb.limit_blocks();
        sel = $urandom_range(99);
        if (sel < 3)
            send_item(OP_INIT, $urandom_range(0, 4095), $urandom_range(0, 8191));
        else if (sel < 43)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                cnt = $urandom_range(1, 16);
            else if (pick < 85)
                cnt = $urandom_range(17, 200);
            else if (pick < 93)
                cnt = $urandom_range(1, lim + 2);
            else if (pick < 97)
                cnt = $urandom_range(0, 8191);
            else
                cnt = 0;
            send_item(OP_ALLOC, $urandom_range(0, 4095), cnt);
        end
        else if (sel < 75)
        begin
            if (live_runs.size() != 0 && $urandom_range(3) != 0)
            begin
                pick = $urandom_range(live_runs.size() - 1);
                run  = live_runs[pick];
                live_runs.delete(pick);
                idx = run.first;
                cnt = run.len;
                if ($urandom_range(3) == 0)
                    cnt += $urandom_range(0, 40);
                if (idx == 0)
                begin
                    idx = 1;
                    cnt--;
                end
            end
            else
            begin
                idx = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 4095);
                cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64);
            end
            send_item(OP_FREE, idx, cnt);
        end
        else
        begin
            idx = $urandom_range(1) ? $urandom_range(0, 4095) : $urandom_range(0, lim);
            send_item(OP_QUERY, idx, $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset map: everything used
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 4095, 8191);
        send_item(OP_ALLOC, 0, 1);
        send_item(OP_ALLOC, 4095, 0);
        send_item(OP_FREE, 0, 5);
        send_item(OP_FREE, 10, 0);
        send_item(OP_FREE, 100, 4);
        send_item(OP_ALLOC, 0, 4);
        send_item(OP_ALLOC, 0, 8191);
        // whole map as one run, then free past the end
        send_item(OP_INIT, 0, 0);
        send_item(OP_ALLOC, 0, 4096);
        send_item(OP_ALLOC, 0, 1);
        send_item(OP_FREE, 1, 8191);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_FREE, 4095, 1);
        send_item(OP_ALLOC, 0, 4095);
        send_item(OP_FREE, 4095, 1);
        send_item(OP_QUERY, 4095, 4096);
        // first fit into a hole
        send_item(OP_INIT, 4095, 8191);
        send_item(OP_ALLOC, 0, 100);
        send_item(OP_ALLOC, 0, 50);
        send_item(OP_FREE, 20, 10);
        send_item(OP_ALLOC, 0, 10);
        send_item(OP_ALLOC, 0, 11);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            set_config(phase_total[p], phase_reserved[p]);
            sender_idle_pct = (p % 4 == 1) ? 87 : (p % 4 == 3) ? 10 : 0;
            stall_pct       = (p % 4 == 2) ? 87 : (p % 4 == 3) ? 10 : 0;
            if (phase_init[p])
                send_item(OP_INIT, $urandom_range(0, 4095), $urandom_range(0, 8191));
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if (n == 20 && p % 4 == 2)
                    hold_requests++;
                if (n == 100 && (p == 1 || p == 4))
                    settle();
                idle_gap();
                send_random();
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d init, %0d allocate (%0d refused), %0d free, %0d query requests",
                 sb.op_seen[OP_INIT], sb.op_seen[OP_ALLOC], sb.alloc_refused,
                 sb.op_seen[OP_FREE], sb.op_seen[OP_QUERY]);
        $display("%0d results checked over %0d register settings and four pacing modes, %0d errors",
                 sb.checked, PHASES + 1, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
